// ===== rtl/fq2t_pkg.sv =====
// Package for the fixed-point to decimal text unit: microcode word layout,
// step numbers, the microcode program, character codes and divide-by-ten constants.
// No dependencies.
package fq2t_pkg;

  typedef logic [2:0] step_t;

  typedef enum logic [2:0] {
    SRC_NONE,
    SRC_MINUS,
    SRC_STACK,
    SRC_DOT,
    SRC_FRAC
  } src_t;

  typedef enum logic [2:0] {
    COND_START,
    COND_QNZ,
    COND_STK_MORE,
    COND_FRAC_MORE,
    COND_NEVER
  } cond_t;

  typedef struct packed {
    logic  load;
    logic  div;
    src_t  src;
    cond_t cond;
    step_t t_true;
    step_t t_false;
  } ctl_t;

  typedef struct packed {
    logic qnz;
    logic stk_more;
    logic frac_more;
  } stat_t;

  localparam step_t STEP_IDLE = 3'd0;
  localparam step_t STEP_SIGN = 3'd1;
  localparam step_t STEP_DIV  = 3'd2;
  localparam step_t STEP_POP  = 3'd3;
  localparam step_t STEP_DOT  = 3'd4;
  localparam step_t STEP_FRAC = 3'd5;

  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  localparam logic [31:0] DIV10_MAGIC = 32'hcccc_cccd;
  localparam int          DIV10_SHIFT = 35;

  localparam int STK_DEPTH = 8;
  localparam int SP_W      = $clog2(STK_DEPTH + 1);

  // The microcode program, one control word per step.
  function automatic ctl_t ucode(step_t s);
    ctl_t c;
    c = '{load: 1'b0, div: 1'b0, src: SRC_NONE, cond: COND_NEVER,
          t_true: STEP_IDLE, t_false: STEP_IDLE};
    case (s)
      STEP_IDLE: begin
        c.load = 1'b1;
        c.cond = COND_START;
        c.t_true = STEP_SIGN;
        c.t_false = STEP_IDLE;
      end
      STEP_SIGN: begin
        c.div = 1'b1;
        c.src = SRC_MINUS;
        c.cond = COND_QNZ;
        c.t_true = STEP_DIV;
        c.t_false = STEP_POP;
      end
      STEP_DIV: begin
        c.div = 1'b1;
        c.cond = COND_QNZ;
        c.t_true = STEP_DIV;
        c.t_false = STEP_POP;
      end
      STEP_POP: begin
        c.src = SRC_STACK;
        c.cond = COND_STK_MORE;
        c.t_true = STEP_POP;
        c.t_false = STEP_DOT;
      end
      STEP_DOT: begin
        c.src = SRC_DOT;
        c.t_false = STEP_FRAC;
      end
      STEP_FRAC: begin
        c.src = SRC_FRAC;
        c.cond = COND_FRAC_MORE;
        c.t_true = STEP_FRAC;
        c.t_false = STEP_IDLE;
      end
      default: begin
        c.t_false = STEP_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/fq2t_useq.sv =====
// Microcode sequencer: step counter, program lookup and conditional jumps.
// Depends on fq2t_pkg.
module fq2t_useq
  import fq2t_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output ctl_t  ctl,
  output logic  busy
);

  step_t pc;
  step_t pc_next;
  logic  taken;

  assign ctl  = ucode(pc);
  assign busy = (pc != STEP_IDLE);

  always_comb begin
    case (ctl.cond)
      COND_START:     taken = start;
      COND_QNZ:       taken = stat.qnz;
      COND_STK_MORE:  taken = stat.stk_more;
      COND_FRAC_MORE: taken = stat.frac_more;
      default:        taken = 1'b0;
    endcase
    pc_next = taken ? ctl.t_true : ctl.t_false;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ===== rtl/fq2t_datapath.sv =====
// Datapath: magnitude split, divide-by-ten digit stack, fraction times-ten unit
// and the registered character output. Depends on fq2t_pkg.
module fq2t_datapath
  import fq2t_pkg::*;
#(
  parameter int FRAC_DIGITS = 6,
  parameter int FRAC_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] value,
  input  ctl_t               ctl,
  output stat_t              stat,
  output logic [7:0]         char_code,
  output logic               last,
  output logic               strobe
);

  localparam int IW = 32 - FRAC_BITS;
  localparam int FW = $clog2(FRAC_DIGITS + 1);

  logic                    neg;
  logic [IW-1:0]           ipart;
  logic [FRAC_BITS-1:0]    frac;
  logic [FW-1:0]           fcnt;
  logic [3:0]              stk [STK_DEPTH];
  logic [SP_W-1:0]         sp;

  logic [31:0]             mag;
  logic [IW+31:0]          prod;
  logic [IW-1:0]           q;
  logic [IW-1:0]           q10;
  logic [IW-1:0]           rem_full;
  logic [FRAC_BITS+3:0]    prod10;
  logic [3:0]              fdig;
  logic                    emit;
  logic [7:0]              ch;
  logic                    last_c;

  assign mag = value[31] ? (32'd0 - $unsigned(value)) : $unsigned(value);

  assign prod     = (IW+32)'(ipart) * (IW+32)'(DIV10_MAGIC);
  assign q        = IW'(prod >> DIV10_SHIFT);
  assign q10      = {q[IW-4:0], 3'b000} + {q[IW-2:0], 1'b0};
  assign rem_full = ipart - q10;

  assign prod10 = {1'b0, frac, 3'b000} + {3'b000, frac, 1'b0};
  assign fdig   = prod10[FRAC_BITS+3:FRAC_BITS];

  assign stat.qnz       = (q != '0);
  assign stat.stk_more  = (sp != SP_W'(1));
  assign stat.frac_more = (fcnt != FW'(1));

  always_comb begin
    emit   = 1'b0;
    ch     = CH_ZERO;
    last_c = 1'b0;
    case (ctl.src)
      SRC_MINUS: begin
        emit = neg;
        ch   = CH_MINUS;
      end
      SRC_STACK: begin
        emit = 1'b1;
        ch   = CH_ZERO + {4'b0000, stk[0]};
      end
      SRC_DOT: begin
        emit = 1'b1;
        ch   = CH_DOT;
      end
      SRC_FRAC: begin
        emit   = 1'b1;
        ch     = CH_ZERO + {4'b0000, fdig};
        last_c = (fcnt == FW'(1));
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
      sp     <= '0;
      fcnt   <= '0;
    end else begin
      strobe <= emit;
      if (ctl.load && start) begin
        sp   <= '0;
        fcnt <= FW'(FRAC_DIGITS);
      end else if (ctl.div) begin
        sp <= sp + SP_W'(1);
      end else if (ctl.src == SRC_STACK) begin
        sp <= sp - SP_W'(1);
      end else if (ctl.src == SRC_FRAC) begin
        fcnt <= fcnt - FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    char_code <= ch;
    last      <= last_c;
    if (ctl.load && start) begin
      neg   <= value[31];
      ipart <= mag[31:FRAC_BITS];
      frac  <= mag[FRAC_BITS-1:0];
    end else if (ctl.div) begin
      ipart  <= q;
      stk[0] <= rem_full[3:0];
      for (int i = 1; i < STK_DEPTH; i++) begin
        stk[i] <= stk[i-1];
      end
    end else if (ctl.src == SRC_STACK) begin
      for (int i = 0; i < STK_DEPTH - 1; i++) begin
        stk[i] <= stk[i+1];
      end
    end else if (ctl.src == SRC_FRAC) begin
      frac <= prod10[FRAC_BITS-1:0];
    end
  end

endmodule

// ===== rtl/fixed_q16_to_decimal_text_unit.sv =====
// Top level of the fixed-point to decimal text unit.
// Depends on fq2t_pkg, fq2t_useq and fq2t_datapath.
//
// Usage: drive value and raise start while busy is low; the word is taken at
// that clock edge. The unit then sends the decimal text one character per
// word on char_code, each shown for one cycle with strobe high; last marks
// the final character. The text is an optional minus sign, the integer digits
// without leading zeros, a point and FRAC_DIGITS truncated fraction digits.
// Sequence: a microcoded sequencer spends one step per integer digit to divide
// by ten and one step per digit to send it, then one step for the point and
// one per fraction digit. The sign step emits nothing for a positive value.
// busy falls in the cycle that shows the last character, so the next word
// can be taken then. The receiver cannot stall the unit; every strobe cycle
// must be taken. Reset returns the sequencer to idle and drops strobe.
module fixed_q16_to_decimal_text_unit
  import fq2t_pkg::*;
#(
  parameter int FRAC_DIGITS = 6,
  parameter int FRAC_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] value,
  output logic               busy,
  output logic [7:0]         char_code,
  output logic               last,
  output logic               strobe
);

  ctl_t  ctl;
  stat_t stat;

  fq2t_useq u_useq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy)
  );

  fq2t_datapath #(
    .FRAC_DIGITS (FRAC_DIGITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .value     (value),
    .ctl       (ctl),
    .stat      (stat),
    .char_code (char_code),
    .last      (last),
    .strobe    (strobe)
  );

endmodule

// ===== rtl/fq2t_checker.sv =====
// Port-level checks for the fixed-point to decimal text unit, and the bind
// that attaches them to the top level. Depends on fixed_q16_to_decimal_text_unit.
module fq2t_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic last,
  input logic strobe
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("Unit not busy after accepting a word.");

  a_accept_quiet: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> !strobe)
    else $error("Character sent right after accepting a word.");

  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("Unit idle while text is still being sent.");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> !busy)
    else $error("Unit still busy on the final character.");

  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !strobe)
    else $error("Character sent directly after the final character.");

endmodule

bind fixed_q16_to_decimal_text_unit fq2t_checker u_fq2t_checker (.*);

// ===== verif/fq2t_text_checker.sv =====
// Checker for the fixed-point to decimal text unit: watches accepted words and
// character strobes, predicts the text of each word and compares it field by field.
// Depends on fq2t_pkg for the character codes.
module fq2t_text_checker
  import fq2t_pkg::*;
#(
  parameter int FRAC_DIGITS = 6,
  parameter int FRAC_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] value,
  input  logic        busy,
  input  logic [7:0]  char_code,
  input  logic        last,
  input  logic        strobe,
  output int          errors,
  output int          pending
);

  logic [7:0] exp_chars[$];
  logic       exp_lasts[$];
  int         fail_count = 0;

  assign errors = fail_count;

  task automatic push_char(input logic [7:0] ch, input logic is_last);
    exp_chars.push_back(ch);
    exp_lasts.push_back(is_last);
  endtask

  task automatic predict_text(input logic [31:0] word);
    logic [31:0] mag;
    logic [31:0] ipart;
    logic [63:0] frac_mask;
    logic [63:0] frac;
    logic [63:0] prod;
    logic [7:0]  digs[$];
    int          i;
    mag = word[31] ? (32'd0 - word) : word;
    ipart = mag >> FRAC_BITS;
    frac_mask = (64'd1 << FRAC_BITS) - 64'd1;
    frac = {32'd0, mag} & frac_mask;
    if (word[31]) begin
      push_char(CH_MINUS, 1'b0);
    end
    do begin
      digs.push_front(CH_ZERO + 8'(ipart % 10));
      ipart = ipart / 10;
    end while (ipart != 0);
    foreach (digs[k]) begin
      push_char(digs[k], 1'b0);
    end
    push_char(CH_DOT, 1'b0);
    for (i = 0; i < FRAC_DIGITS; i++) begin
      prod = frac * 64'd10;
      push_char(CH_ZERO + 8'(prod >> FRAC_BITS), i == FRAC_DIGITS - 1);
      frac = prod & frac_mask;
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (strobe) begin
        if (exp_chars.size() == 0) begin
          $error("unexpected word: char_code %h last %b", char_code, last);
          fail_count++;
        end else begin
          if (char_code !== exp_chars[0]) begin
            $error("char_code mismatch: expected %h, actual %h", exp_chars[0], char_code);
            fail_count++;
          end
          if (last !== exp_lasts[0]) begin
            $error("last mismatch: expected %b, actual %b", exp_lasts[0], last);
            fail_count++;
          end
          void'(exp_chars.pop_front());
          void'(exp_lasts.pop_front());
        end
      end
      if (start && !busy) begin
        predict_text(value);
      end
      pending <= exp_chars.size();
    end
  end

endmodule

// ===== verif/tb_fixed_q16_to_decimal_text_unit.sv =====
// Testbench top for the fixed-point to decimal text unit: drives corner and random
// words with random gaps and gives the verdict from the checker's failure count.
// Depends on fq2t_pkg, fixed_q16_to_decimal_text_unit and fq2t_text_checker.
module tb_fixed_q16_to_decimal_text_unit;
  import fq2t_pkg::*;

  localparam int RANDOM_WORDS = 78;
  localparam int CYCLE_LIMIT  = 60000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic signed [31:0] value = '0;
  logic               busy;
  logic [7:0]         char_code;
  logic               last;
  logic               strobe;
  int                 errors;
  int                 pending;
  int                 cycles = 0;
  logic               no_gaps = 1'b0;

  logic [31:0] corner_words [22] = '{
    32'h0000_0000, 32'h0000_0001, 32'hffff_ffff, 32'h7fff_ffff,
    32'h8000_0000, 32'h8000_0001, 32'h0001_0000, 32'hffff_0000,
    32'h0000_ffff, 32'h0000_8000, 32'h0009_ffff, 32'h000a_0000,
    32'h0063_ffff, 32'h0064_0000, 32'h03e7_0000, 32'h270f_ffff,
    32'h2710_0000, 32'hfff6_0000, 32'h5555_5555, 32'haaaa_aaaa,
    32'h0000_1999, 32'h7fff_0000
  };

  always #1 clk = ~clk;

  fixed_q16_to_decimal_text_unit uut (
    .clk(clk), .rst(rst), .start(start), .value(value), .busy(busy),
    .char_code(char_code), .last(last), .strobe(strobe)
  );

  fq2t_text_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .value(value), .busy(busy),
    .char_code(char_code), .last(last), .strobe(strobe),
    .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_word(input logic [31:0] word);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    value <= word;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [31:0] random_word();
    logic [31:0] w;
    logic [15:0] ipart;
    int          digits;
    int          lo;
    int          hi;
    if ($urandom_range(0, 2) == 0) begin
      w = $urandom;
    end else begin
      digits = $urandom_range(1, 5);
      lo = (digits == 1) ? 0 : 10 ** (digits - 1);
      hi = (digits == 5) ? 32767 : 10 ** digits - 1;
      ipart = 16'($urandom_range(lo, hi));
      w = {ipart, 16'($urandom)};
      if ($urandom_range(0, 1) == 1) begin
        w = 32'd0 - w;
      end
    end
    return w;
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    foreach (corner_words[i]) begin
      send_word(corner_words[i]);
    end
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 16 == 0) begin
        no_gaps = ($urandom_range(0, 2) == 0);
      end
      send_word(random_word());
    end
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (24) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/fq2t_pkg.sv
rtl/fq2t_useq.sv
rtl/fq2t_datapath.sv
rtl/fixed_q16_to_decimal_text_unit.sv
rtl/fq2t_checker.sv
verif/fq2t_text_checker.sv
verif/tb_fixed_q16_to_decimal_text_unit.sv
